>>> sv/flv_pkg.sv
package flv_pkg;

    // default sizes
    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_COUNT_BITS = 32;
    localparam int DEF_TIME_BITS  = 32;

    // fixed field widths
    localparam int SLOT_BITS  = 6;
    localparam int SIZE_BITS  = 32;
    localparam int TOTAL_BITS = 48;
    localparam int FILES_BITS = 7;

    // actions
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TOUCH  = 2'd2;
    localparam logic [1:0] ACT_VICTIM = 2'd3;

    // result status
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BUSY   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_NO_VIC = 2'd3;

    // policies
    localparam logic [1:0] POL_FIFO    = 2'd0;
    localparam logic [1:0] POL_LFU     = 2'd1;
    localparam logic [1:0] POL_LRU     = 2'd2;
    localparam logic [1:0] POL_INVALID = 2'd3;

    // command broadcast to the cells
    typedef enum logic [1:0] {
        OP_NONE,
        OP_REMOVE,
        OP_TOUCH
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [SLOT_BITS-1:0] slot;
    } t_cmd;

    // victim scan setup, held for the whole scan
    typedef struct packed {
        logic                 fifo;
        logic                 use_time;
        logic                 excl_on;
        logic [SLOT_BITS-1:0] excl;
    } t_scan;

    typedef struct packed {
        logic [1:0]           action;
        logic [SLOT_BITS-1:0] slot;
        logic [SIZE_BITS-1:0] file_size;
        logic [SLOT_BITS-1:0] exclude_slot;
        logic                 exclude_valid;
        logic [31:0]          now;
    } t_in;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  victim_slot;
        logic                  victim_found;
        logic [FILES_BITS-1:0] file_count;
        logic [TOTAL_BITS-1:0] total_bytes;
    } t_out;

endpackage

>>> sv/flv_cell.sv
module flv_cell #(
    parameter int COUNT_BITS = flv_pkg::DEF_COUNT_BITS,
    parameter int TIME_BITS  = flv_pkg::DEF_TIME_BITS,
    parameter int KEY_BITS   = flv_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  flv_pkg::t_cmd                  i_cmd,
    input  logic                           i_add_en,
    input  logic [flv_pkg::SLOT_BITS-1:0]  i_add_slot,
    input  logic [TIME_BITS-1:0]           i_now,
    input  logic [flv_pkg::SIZE_BITS-1:0]  i_size,
    input  flv_pkg::t_scan                 i_scan,
    // right neighbour contents
    input  logic                           i_nxt_vld,
    input  logic [flv_pkg::SLOT_BITS-1:0]  i_nxt_slot,
    input  logic [COUNT_BITS-1:0]          i_nxt_cnt,
    input  logic [TIME_BITS-1:0]           i_nxt_time,
    input  logic [flv_pkg::SIZE_BITS-1:0]  i_nxt_size,
    output logic                           o_vld,
    output logic [flv_pkg::SLOT_BITS-1:0]  o_slot,
    output logic [COUNT_BITS-1:0]          o_cnt,
    output logic [TIME_BITS-1:0]           o_time,
    output logic [flv_pkg::SIZE_BITS-1:0]  o_size,
    output logic                           o_match,
    // removal bubble from the left
    input  logic                           i_kill,
    output logic                           o_kill,
    // scan wave from the left
    input  logic                           i_wv,
    input  logic                           i_wh,
    input  logic [KEY_BITS-1:0]            i_wkey,
    input  logic [flv_pkg::SLOT_BITS-1:0]  i_wslot,
    output logic                           o_wv,
    output logic                           o_wh,
    output logic [KEY_BITS-1:0]            o_wkey,
    output logic [flv_pkg::SLOT_BITS-1:0]  o_wslot
);

    logic                          r_vld;
    logic [flv_pkg::SLOT_BITS-1:0] r_slot;
    logic [COUNT_BITS-1:0]         r_cnt;
    logic [TIME_BITS-1:0]          r_time;
    logic [flv_pkg::SIZE_BITS-1:0] r_size;
    logic                          r_kill;
    logic                          r_wv;
    logic                          r_wh;
    logic [KEY_BITS-1:0]           r_wkey;
    logic [flv_pkg::SLOT_BITS-1:0] r_wslot;

    logic                          s_match;
    logic [KEY_BITS-1:0]           s_key;
    logic                          s_take;

    assign s_match = r_vld && (r_slot == i_cmd.slot);
    assign s_key   = i_scan.use_time ? KEY_BITS'(r_time) : KEY_BITS'(r_cnt);

    // this entry wins if eligible and either first eligible, or strictly better when not under fifo
    assign s_take = r_vld && !(i_scan.excl_on && (r_slot == i_scan.excl)) &&
                    (!i_wh || (!i_scan.fifo && (s_key < i_wkey)));

    // entry contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_kill <= 1'b0;
        end else begin
            r_kill <= i_kill || ((i_cmd.op == flv_pkg::OP_REMOVE) && s_match);
            if (i_add_en) begin
                r_vld  <= 1'b1;
                r_slot <= i_add_slot;
                r_cnt  <= '0;
                r_time <= i_now;
                r_size <= i_size;
            end else if (r_kill) begin
                r_vld  <= i_nxt_vld;
                r_slot <= i_nxt_slot;
                r_cnt  <= i_nxt_cnt;
                r_time <= i_nxt_time;
                r_size <= i_nxt_size;
            end else if ((i_cmd.op == flv_pkg::OP_TOUCH) && s_match) begin
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + COUNT_BITS'(1);
                end
                r_time <= i_now;
            end
        end
    end

    // scan wave stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else begin
            r_wv <= i_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wv) begin
            if (s_take) begin
                r_wh    <= 1'b1;
                r_wkey  <= s_key;
                r_wslot <= r_slot;
            end else begin
                r_wh    <= i_wh;
                r_wkey  <= i_wkey;
                r_wslot <= i_wslot;
            end
        end
    end

    assign o_vld   = r_vld;
    assign o_slot  = r_slot;
    assign o_cnt   = r_cnt;
    assign o_time  = r_time;
    assign o_size  = r_size;
    assign o_match = s_match;
    assign o_kill  = r_kill;
    assign o_wv    = r_wv;
    assign o_wh    = r_wh;
    assign o_wkey  = r_wkey;
    assign o_wslot = r_wslot;

endmodule

>>> sv/fifo_lfu_lru_victim_selector.sv
// add, touch and rejected actions: result registered in the cycle after acceptance
// remove: result once the shift state has let the bubble close the gap in the cell row
// choose victim: result once the scan wave has crossed every cell
// one transaction in flight at a time; next input taken once the result has left
// synchronous active-low reset empties the list, clears the byte total and sets policy to fifo
module fifo_lfu_lru_victim_selector #(
    parameter int ENTRIES    = flv_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = flv_pkg::DEF_COUNT_BITS,
    parameter int TIME_BITS  = flv_pkg::DEF_TIME_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  flv_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output flv_pkg::t_out o_out
);

    localparam int LEN_W    = $clog2(ENTRIES + 1);
    localparam int CNT_W    = $clog2(ENTRIES);
    localparam int KEY_BITS = (COUNT_BITS > TIME_BITS) ? COUNT_BITS : TIME_BITS;
    localparam int SB       = flv_pkg::SLOT_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [1:0]                       r_policy;
    logic [LEN_W-1:0]                 r_len, n_len;
    logic [flv_pkg::TOTAL_BITS-1:0]   r_total, n_total;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    flv_pkg::t_scan                   r_scan, n_scan;
    flv_pkg::t_out                    r_out, n_out;

    flv_pkg::t_cmd                    s_cmd;
    logic                             s_accept;
    logic                             s_start;
    logic                             s_occ;
    logic [flv_pkg::SIZE_BITS-1:0]    s_hit_size;
    logic                             s_in_range;
    logic [TIME_BITS-1:0]             s_now;
    logic [ENTRIES-1:0]               s_add_en;
    logic [ENTRIES-1:0]               s_match;
    logic [ENTRIES-1:0]               s_killv;

    logic                             c_vld  [ENTRIES+1];
    logic [SB-1:0]                    c_slot [ENTRIES+1];
    logic [COUNT_BITS-1:0]            c_cnt  [ENTRIES+1];
    logic [TIME_BITS-1:0]             c_time [ENTRIES+1];
    logic [flv_pkg::SIZE_BITS-1:0]    c_size [ENTRIES+1];
    logic                             k_chain[ENTRIES+1];
    logic                             w_v    [ENTRIES+1];
    logic                             w_h    [ENTRIES+1];
    logic [KEY_BITS-1:0]              w_key  [ENTRIES+1];
    logic [SB-1:0]                    w_slot [ENTRIES+1];

    assign s_accept   = i_valid && !o_stall;
    assign s_in_range = 32'(i_in.slot) < 32'(ENTRIES);
    assign s_now      = TIME_BITS'(i_in.now);

    // chain ends
    assign c_vld[ENTRIES]  = 1'b0;
    assign c_slot[ENTRIES] = '0;
    assign c_cnt[ENTRIES]  = '0;
    assign c_time[ENTRIES] = '0;
    assign c_size[ENTRIES] = '0;
    assign k_chain[0]      = 1'b0;
    assign w_v[0]          = s_start;
    assign w_h[0]          = 1'b0;
    assign w_key[0]        = '0;
    assign w_slot[0]       = '0;

    // row of cells in insertion order
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign s_add_en[g] = s_accept && (i_in.action == flv_pkg::ACT_ADD) && s_in_range &&
                             !s_occ && (r_len == LEN_W'(g));
        assign s_killv[g]  = k_chain[g+1];
        flv_cell #(
            .COUNT_BITS (COUNT_BITS),
            .TIME_BITS  (TIME_BITS),
            .KEY_BITS   (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (s_cmd),
            .i_add_en   (s_add_en[g]),
            .i_add_slot (i_in.slot),
            .i_now      (s_now),
            .i_size     (i_in.file_size),
            .i_scan     (r_scan),
            .i_nxt_vld  (c_vld[g+1]),
            .i_nxt_slot (c_slot[g+1]),
            .i_nxt_cnt  (c_cnt[g+1]),
            .i_nxt_time (c_time[g+1]),
            .i_nxt_size (c_size[g+1]),
            .o_vld      (c_vld[g]),
            .o_slot     (c_slot[g]),
            .o_cnt      (c_cnt[g]),
            .o_time     (c_time[g]),
            .o_size     (c_size[g]),
            .o_match    (s_match[g]),
            .i_kill     (k_chain[g]),
            .o_kill     (k_chain[g+1]),
            .i_wv       (w_v[g]),
            .i_wh       (w_h[g]),
            .i_wkey     (w_key[g]),
            .i_wslot    (w_slot[g]),
            .o_wv       (w_v[g+1]),
            .o_wh       (w_h[g+1]),
            .o_wkey     (w_key[g+1]),
            .o_wslot    (w_slot[g+1])
        );
    end

    // occupancy and stored size of the addressed slot
    always_comb begin
        s_occ      = 1'b0;
        s_hit_size = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            s_occ      = s_occ | s_match[i];
            s_hit_size = s_hit_size | (s_match[i] ? c_size[i] : '0);
        end
    end

    // control sequencer
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_total = r_total;
        n_cnt   = r_cnt;
        n_scan  = r_scan;
        n_out   = r_out;
        s_cmd   = '{op: flv_pkg::OP_NONE, slot: i_in.slot};
        s_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_out              = '0;
                    n_out.status       = flv_pkg::STAT_OK;
                    n_state            = ST_OUT;
                    case (i_in.action)
                        flv_pkg::ACT_ADD: begin
                            if (!s_in_range || s_occ) begin
                                n_out.status = flv_pkg::STAT_BUSY;
                            end else if (r_len < LEN_W'(ENTRIES)) begin
                                n_len   = r_len + LEN_W'(1);
                                n_total = r_total + flv_pkg::TOTAL_BITS'(i_in.file_size);
                            end
                        end
                        flv_pkg::ACT_REMOVE: begin
                            if (!s_occ) begin
                                n_out.status = flv_pkg::STAT_EMPTY;
                            end else begin
                                s_cmd.op = flv_pkg::OP_REMOVE;
                                n_len    = r_len - LEN_W'(1);
                                n_total  = r_total - flv_pkg::TOTAL_BITS'(s_hit_size);
                                n_cnt    = '0;
                                n_state  = ST_SHIFT;
                            end
                        end
                        flv_pkg::ACT_TOUCH: begin
                            if (!s_occ) begin
                                n_out.status = flv_pkg::STAT_EMPTY;
                            end else begin
                                s_cmd.op = flv_pkg::OP_TOUCH;
                            end
                        end
                        default: begin
                            if ((r_policy != flv_pkg::POL_FIFO) &&
                                (r_policy != flv_pkg::POL_LFU) &&
                                (r_policy != flv_pkg::POL_LRU) || (r_len == '0)) begin
                                n_out.status = flv_pkg::STAT_NO_VIC;
                            end else begin
                                n_scan.fifo     = (r_policy == flv_pkg::POL_FIFO);
                                n_scan.use_time = (r_policy == flv_pkg::POL_LRU);
                                n_scan.excl_on  = i_in.exclude_valid;
                                n_scan.excl     = i_in.exclude_slot;
                                n_state         = ST_SCAN;
                            end
                        end
                    endcase
                    n_out.file_count  = flv_pkg::FILES_BITS'(n_len);
                    n_out.total_bytes = n_total;
                end
            end
            ST_SHIFT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ENTRIES - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_SCAN: begin
                // first scan cycle launches the wave once the setup is held
                s_start = (r_cnt == '0) && !w_v[ENTRIES];
                n_cnt   = CNT_W'(1);
                if (w_v[ENTRIES]) begin
                    n_out.status       = w_h[ENTRIES] ? flv_pkg::STAT_OK : flv_pkg::STAT_NO_VIC;
                    n_out.victim_found = w_h[ENTRIES];
                    n_out.victim_slot  = w_h[ENTRIES] ? w_slot[ENTRIES] : '0;
                    n_state            = ST_OUT;
                end
            end
            ST_OUT: begin
                n_cnt = '0;
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_policy <= flv_pkg::POL_FIFO;
            r_len    <= '0;
            r_total  <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_total <= n_total;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_policy <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_out  <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_out   = r_out;

    // checks
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(ENTRIES))
        else $error("list length beyond table size");

    a_no_bubble_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (s_killv == '0))
        else $error("removal bubble alive during victim scan");

    a_remove_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_in.action == flv_pkg::ACT_REMOVE) && s_occ) |=> (r_state == ST_SHIFT))
        else $error("successful remove did not start compaction");

    a_no_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.victim_found) |-> (o_out.victim_slot == '0))
        else $error("victim slot set without a victim");

endmodule

>>> sim/fifo_lfu_lru_victim_selector_tb.sv
module fifo_lfu_lru_victim_selector_tb;

    localparam int NSLOT     = 64;
    localparam int LATENCY   = NSLOT + 4;
    localparam int CYC_LIMIT = 1500000;

    // scoreboard: table model plus queue of expected transactions
    class victim_tracker;
        logic [1:0]    policy;
        bit            busy[NSLOT];
        logic [31:0]   hits[NSLOT];
        logic [31:0]   stamp[NSLOT];
        logic [31:0]   bytes[NSLOT];
        logic [5:0]    order[$];
        logic [47:0]   total;
        flv_pkg::t_out pending[$];
        int            errors;
        int            checked;

        function void clear();
            policy = flv_pkg::POL_FIFO;
            foreach (busy[k]) busy[k] = 0;
            order.delete();
            total = '0;
            pending.delete();
        endfunction

        // apply one accepted transaction and queue its result
        function void note_input(flv_pkg::t_in it);
            flv_pkg::t_out r;
            int start, best;
            logic [31:0] key, best_key;
            r = '0;
            r.status = flv_pkg::STAT_OK;
            case (it.action)
                flv_pkg::ACT_ADD: begin
                    if (busy[it.slot]) r.status = flv_pkg::STAT_BUSY;
                    else begin
                        busy[it.slot] = 1;
                        hits[it.slot] = 0;
                        stamp[it.slot] = it.now;
                        bytes[it.slot] = it.file_size;
                        order.push_back(it.slot);
                        total = total + 48'(it.file_size);
                    end
                end
                flv_pkg::ACT_REMOVE: begin
                    if (!busy[it.slot]) r.status = flv_pkg::STAT_EMPTY;
                    else begin
                        busy[it.slot] = 0;
                        foreach (order[k]) if (order[k] == it.slot) begin
                            order.delete(k);
                            break;
                        end
                        total = total - 48'(bytes[it.slot]);
                    end
                end
                flv_pkg::ACT_TOUCH: begin
                    if (!busy[it.slot]) r.status = flv_pkg::STAT_EMPTY;
                    else begin
                        if (hits[it.slot] != '1) hits[it.slot]++;
                        stamp[it.slot] = it.now;
                    end
                end
                default: begin
                    start = (it.exclude_valid && order.size() > 0 &&
                             order[0] == it.exclude_slot) ? 1 : 0;
                    if (policy > flv_pkg::POL_LRU || start >= order.size()) begin
                        r.status = flv_pkg::STAT_NO_VIC;
                    end else begin
                        best = order[start];
                        best_key = (policy == flv_pkg::POL_LFU) ? hits[best] : stamp[best];
                        if (policy != flv_pkg::POL_FIFO)
                            for (int k = start + 1; k < order.size(); k++) begin
                                if (it.exclude_valid && order[k] == it.exclude_slot)
                                    continue;
                                key = (policy == flv_pkg::POL_LFU) ? hits[order[k]]
                                                                   : stamp[order[k]];
                                if (key < best_key) begin
                                    best_key = key;
                                    best = order[k];
                                end
                            end
                        r.victim_slot = 6'(best);
                        r.victim_found = 1;
                    end
                end
            endcase
            r.file_count = 7'(order.size());
            r.total_bytes = total;
            pending.push_back(r);
        endfunction

        function void check_result(flv_pkg::t_out got);
            flv_pkg::t_out w;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status || got.victim_slot !== w.victim_slot ||
                got.victim_found !== w.victim_found ||
                got.file_count !== w.file_count ||
                got.total_bytes !== w.total_bytes) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p got %p", w, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_cfg_we = 0, i_valid = 0, i_stall = 0;
    logic [1:0] i_cfg_data = '0;
    logic o_stall, o_valid;
    flv_pkg::t_in  i_in = '0;
    flv_pkg::t_out o_out;

    victim_tracker tracker;
    int send_idle, recv_stall, hold_off;
    int cycles, sent;
    int n_found;

    fifo_lfu_lru_victim_selector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .o_stall(o_stall),
        .i_in(i_in), .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out));

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_out.victim_found) n_found++;
            tracker.check_result(o_out);
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_stall <= 1;
        end else
            i_stall <= ($urandom_range(99) < recv_stall);
    end

    // valid stays up between back-to-back transactions and drops only when idling
    task automatic send(flv_pkg::t_in it);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_in <= it;
        i_valid <= 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_input(it);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (tracker.pending.size() > 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= p;
        @(negedge i_clk);
        i_cfg_we <= 0;
        tracker.policy = p;
    endtask

    function automatic flv_pkg::t_in make_op(logic [1:0] a, logic [5:0] s);
        flv_pkg::t_in it;
        it.action = a;
        it.slot = s;
        it.file_size = $urandom();
        it.exclude_slot = 6'($urandom_range(63));
        it.exclude_valid = 1'($urandom_range(1));
        it.now = $urandom();
        return it;
    endfunction

    // mostly valid operations on occupied slots, some noise
    function automatic flv_pkg::t_in random_op();
        flv_pkg::t_in it;
        int r;
        r = $urandom_range(99);
        it = make_op(2'($urandom_range(3)), 6'($urandom_range(63)));
        if (tracker.order.size() > 0 && r < 75) begin
            if (it.action == flv_pkg::ACT_ADD && r < 40) it.slot = 6'($urandom_range(63));
            else if (it.action != flv_pkg::ACT_ADD)
                it.slot = tracker.order[$urandom_range(tracker.order.size() - 1)];
            if (it.action == flv_pkg::ACT_VICTIM && r < 50)
                it.exclude_slot = tracker.order[$urandom_range(
                    tracker.order.size() > 2 ? 2 : tracker.order.size() - 1)];
        end
        // narrow time stamps often, so ties occur
        if ($urandom_range(3) == 0) it.now = $urandom_range(3);
        if ($urandom_range(15) == 0) it.file_size = 32'hFFFF_FFFF;
        return it;
    endfunction

    initial begin
        flv_pkg::t_in it;
        tracker = new();
        tracker.clear();
        send_idle = 0; recv_stall = 0; hold_off = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: empty table, extremes, each special case
        send(make_op(flv_pkg::ACT_VICTIM, 0));
        send(make_op(flv_pkg::ACT_REMOVE, 5));
        send(make_op(flv_pkg::ACT_TOUCH, 63));
        it = make_op(flv_pkg::ACT_ADD, 0);  it.file_size = '1; it.now = '1; send(it);
        it = make_op(flv_pkg::ACT_ADD, 63); it.file_size = '0; it.now = '0; send(it);
        it = make_op(flv_pkg::ACT_ADD, 63); send(it);
        it = make_op(flv_pkg::ACT_ADD, 17); it.now = 0; send(it);
        it = make_op(flv_pkg::ACT_VICTIM, 0);
        it.exclude_valid = 1; it.exclude_slot = 0; send(it);
        it = make_op(flv_pkg::ACT_VICTIM, 0); it.exclude_valid = 0; send(it);
        set_policy(flv_pkg::POL_LFU);
        send(make_op(flv_pkg::ACT_TOUCH, 0));
        it = make_op(flv_pkg::ACT_VICTIM, 0);
        it.exclude_valid = 1; it.exclude_slot = 63; send(it);
        set_policy(flv_pkg::POL_LRU);
        it = make_op(flv_pkg::ACT_VICTIM, 0);
        it.exclude_valid = 1; it.exclude_slot = 17; send(it);
        it = make_op(flv_pkg::ACT_VICTIM, 0); it.exclude_valid = 0; send(it);
        set_policy(flv_pkg::POL_INVALID);
        send(make_op(flv_pkg::ACT_VICTIM, 0));
        set_policy(flv_pkg::POL_FIFO);
        send(make_op(flv_pkg::ACT_REMOVE, 0));
        it = make_op(flv_pkg::ACT_VICTIM, 0);
        it.exclude_valid = 1; it.exclude_slot = 63; send(it);
        send(make_op(flv_pkg::ACT_REMOVE, 63));
        send(make_op(flv_pkg::ACT_REMOVE, 17));

        // fill the whole table
        for (int s = 0; s < NSLOT; s++) send(make_op(flv_pkg::ACT_ADD, 6'(s)));
        send(make_op(flv_pkg::ACT_VICTIM, 0));

        // random phases across policies and idling patterns
        for (int ph = 0; ph < 12; ph++) begin
            set_policy(2'(ph % 4));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 51; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 51; end
                default: begin send_idle = 21; recv_stall = 21; end
            endcase
            if (ph == 2) hold_off = 300;
            for (int k = 0; k < 120; k++) send(random_op());
        end
        // a saturating counter is not reachable in a short run; clear table instead
        for (int s = 0; s < NSLOT; s++) send(make_op(flv_pkg::ACT_REMOVE, 6'(s)));
        send(make_op(flv_pkg::ACT_VICTIM, 0));
        drain();

        $display("%0d transactions sent, %0d results checked, %0d victims found",
                 sent, tracker.checked, n_found);
        $display("all four policy settings, full and empty table, idle and stall phases");
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("TEST PASSED");
        else begin
            $display("%0d mismatches, %0d left over", tracker.errors,
                     tracker.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/flv_pkg.sv
sv/flv_cell.sv
sv/fifo_lfu_lru_victim_selector.sv
sim/fifo_lfu_lru_victim_selector_tb.sv
